// ----- src/wcct_pkg.sv -----
`default_nettype none

package wcct_pkg;

    // Field widths
    localparam int POS_W      = 26;
    localparam int STEP_W     = 21;
    localparam int FRAC_W     = 16;
    localparam int IDX_OUT_W  = 4;
    localparam int CFG_DIM_W  = 10;
    localparam int RAD_W      = 9;
    localparam int SQ_W       = 2 * POS_W;
    localparam int RES_LIMIT  = 16;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_FIELD_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FIELD_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_OBJECT_RADIUS = 2'd2;
    localparam logic [CFG_DIM_W-1:0] FIELD_RESET  = 10'd704;
    localparam logic [RAD_W-1:0]     RADIUS_RESET = 9'd16;

    // Microcode addresses
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;
    localparam t_upc UPC_IDLE      = 4'd0;
    localparam t_upc UPC_SPAWN     = 4'd1;
    localparam t_upc UPC_EMPTY     = 4'd2;
    localparam t_upc UPC_MOVE      = 4'd3;
    localparam t_upc UPC_MOVE_D0   = 4'd4;
    localparam t_upc UPC_MOVE_D1   = 4'd5;
    localparam t_upc UPC_PAIR_LD   = 4'd6;
    localparam t_upc UPC_PAIR_LAT  = 4'd7;
    localparam t_upc UPC_PAIR      = 4'd8;
    localparam t_upc UPC_PAIR_NXT  = 4'd9;
    localparam t_upc UPC_PAIR_D0   = 4'd10;
    localparam t_upc UPC_PAIR_D1   = 4'd11;
    localparam t_upc UPC_REPORT    = 4'd12;
    localparam t_upc UPC_REPORT_D  = 4'd13;

    typedef enum logic {
        ADDR_I,
        ADDR_J
    } t_addr_sel;

    typedef enum logic [1:0] {
        SINK_NONE,
        SINK_MOVE,
        SINK_PAIR,
        SINK_REPORT
    } t_sink;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_LOAD
    } t_cnt_op;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SPAWN,
        EMIT_EMPTY
    } t_emit;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT,
        COND_DONE,
        COND_MOVE,
        COND_PAIR,
        COND_OUTER,
        COND_FEW,
        COND_REPORT
    } t_cond;

    typedef struct packed {
        t_addr_sel addr;
        t_sink     sink;
        t_cnt_op   i_op;
        t_cnt_op   j_op;
        logic      latch;
        t_emit     emit;
        t_cond     cond;
        t_upc      target;
    } t_uword;

    typedef struct packed {
        logic accept;
        t_upc entry;
        logic move_more;
        logic pair_more;
        logic outer_more;
        logic few;
        logic report_more;
    } t_flags;

    localparam t_uword UW_NOP = '{
        addr:   ADDR_I,
        sink:   SINK_NONE,
        i_op:   CNT_HOLD,
        j_op:   CNT_HOLD,
        latch:  1'b0,
        emit:   EMIT_NONE,
        cond:   COND_NEXT,
        target: UPC_IDLE
    };

endpackage

`default_nettype wire

// ----- src/wcct_ram.sv -----
`default_nettype none

module wcct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/wcct_seq.sv -----
`default_nettype none

module wcct_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wcct_pkg::t_flags  i_flags,
    output wcct_pkg::t_uword  o_uw,
    output logic              o_busy
);

    import wcct_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;

    // Control store: one word per step
    function automatic t_uword ucode(t_upc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            UPC_IDLE: begin
                w.i_op = CNT_CLR;
                w.cond = COND_WAIT;
            end
            UPC_SPAWN: begin
                w.emit = EMIT_SPAWN;
                w.cond = COND_DONE;
            end
            UPC_EMPTY: begin
                w.emit = EMIT_EMPTY;
                w.cond = COND_DONE;
            end
            UPC_MOVE: begin
                w.sink   = SINK_MOVE;
                w.i_op   = CNT_INC;
                w.cond   = COND_MOVE;
                w.target = UPC_MOVE;
            end
            UPC_MOVE_D0: begin
            end
            UPC_MOVE_D1: begin
                w.i_op   = CNT_CLR;
                w.cond   = COND_FEW;
                w.target = UPC_REPORT;
            end
            UPC_PAIR_LD: begin
                w.j_op = CNT_LOAD;
            end
            UPC_PAIR_LAT: begin
                w.latch = 1'b1;
            end
            UPC_PAIR: begin
                w.addr   = ADDR_J;
                w.sink   = SINK_PAIR;
                w.j_op   = CNT_INC;
                w.cond   = COND_PAIR;
                w.target = UPC_PAIR;
            end
            UPC_PAIR_NXT: begin
                w.i_op   = CNT_INC;
                w.cond   = COND_OUTER;
                w.target = UPC_PAIR_LD;
            end
            UPC_PAIR_D0: begin
            end
            UPC_PAIR_D1: begin
                w.i_op = CNT_CLR;
            end
            UPC_REPORT: begin
                w.sink   = SINK_REPORT;
                w.i_op   = CNT_INC;
                w.cond   = COND_REPORT;
                w.target = UPC_REPORT;
            end
            UPC_REPORT_D: begin
                w.cond = COND_DONE;
            end
            default: begin
                w.cond = COND_DONE;
            end
        endcase
        return w;
    endfunction

    always_comb begin
        uw   = ucode(r_pc);
        n_pc = t_upc'(r_pc + 1'b1);
        unique case (uw.cond)
            COND_NEXT:   n_pc = t_upc'(r_pc + 1'b1);
            COND_WAIT:   n_pc = i_flags.accept ? i_flags.entry : r_pc;
            COND_DONE:   n_pc = UPC_IDLE;
            COND_MOVE:   if (i_flags.move_more) n_pc = uw.target;
            COND_PAIR:   if (i_flags.pair_more) n_pc = uw.target;
            COND_OUTER:  if (i_flags.outer_more) n_pc = uw.target;
            COND_FEW:    if (i_flags.few) n_pc = uw.target;
            COND_REPORT: if (i_flags.report_more) n_pc = uw.target;
            default:     n_pc = UPC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uw   = uw;
    assign o_busy = (r_pc != UPC_IDLE);

endmodule

`default_nettype wire

// ----- src/wcct_wrap.sv -----
`default_nettype none

module wcct_wrap #(
    parameter int ADDR_W = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [ADDR_W-1:0]                       i_addr,
    input  logic [wcct_pkg::POS_W-1:0]              i_pos_x,
    input  logic [wcct_pkg::POS_W-1:0]              i_pos_y,
    input  logic signed [wcct_pkg::STEP_W-1:0]      i_step_x,
    input  logic signed [wcct_pkg::STEP_W-1:0]      i_step_y,
    input  logic [wcct_pkg::CFG_DIM_W-1:0]          i_size_x,
    input  logic [wcct_pkg::CFG_DIM_W-1:0]          i_size_y,
    output logic                                    o_valid,
    output logic [ADDR_W-1:0]                       o_addr,
    output logic [wcct_pkg::POS_W-1:0]              o_x,
    output logic [wcct_pkg::POS_W-1:0]              o_y
);

    import wcct_pkg::*;

    localparam int SUM_W = POS_W + 2;

    logic                    r_valid;
    logic [ADDR_W-1:0]       r_addr;
    logic signed [SUM_W-1:0] r_cx;
    logic signed [SUM_W-1:0] r_cy;

    // Fold once into the field, then clamp to the position range
    function automatic logic [POS_W-1:0] fold(logic signed [SUM_W-1:0] c,
                                              logic [CFG_DIM_W-1:0] size);
        logic signed [SUM_W-1:0] lim;
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] top;
        lim = $signed({2'b00, size, {FRAC_W{1'b0}}});
        top = $signed({2'b00, {POS_W{1'b1}}});
        v   = c;
        if (v > lim) begin
            v = v - lim;
        end else if (v < SUM_W'(0)) begin
            v = v + lim;
        end
        if (v < SUM_W'(0)) begin
            return '0;
        end else if (v > top) begin
            return {POS_W{1'b1}};
        end
        return v[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_addr <= i_addr;
        r_cx   <= $signed({2'b00, i_pos_x}) + SUM_W'(i_step_x);
        r_cy   <= $signed({2'b00, i_pos_y}) + SUM_W'(i_step_y);
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_x     = fold(r_cx, i_size_x);
    assign o_y     = fold(r_cy, i_size_y);

endmodule

`default_nettype wire

// ----- src/wcct_dist.sv -----
`default_nettype none

module wcct_dist #(
    parameter int IDX_W = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [IDX_W-1:0]              i_j,
    input  logic [wcct_pkg::POS_W-1:0]    i_xi,
    input  logic [wcct_pkg::POS_W-1:0]    i_yi,
    input  logic [wcct_pkg::POS_W-1:0]    i_xj,
    input  logic [wcct_pkg::POS_W-1:0]    i_yj,
    input  logic [wcct_pkg::SQ_W-1:0]     i_lim,
    output logic                          o_hit,
    output logic [IDX_W-1:0]              o_j
);

    import wcct_pkg::*;

    logic             r_v1;
    logic [IDX_W-1:0] r_j1;
    logic [POS_W-1:0] r_dx;
    logic [POS_W-1:0] r_dy;
    logic             r_v2;
    logic [IDX_W-1:0] r_j2;
    logic [SQ_W-1:0]  r_sx;
    logic [SQ_W-1:0]  r_sy;
    logic [SQ_W:0]    sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_j1 <= i_j;
        r_dx <= (i_xi > i_xj) ? (i_xi - i_xj) : (i_xj - i_xi);
        r_dy <= (i_yi > i_yj) ? (i_yi - i_yj) : (i_yj - i_yi);
        r_j2 <= r_j1;
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
    end

    assign sum   = {1'b0, r_sx} + {1'b0, r_sy};
    assign o_hit = r_v2 && (sum < {1'b0, i_lim});
    assign o_j   = r_j2;

endmodule

`default_nettype wire

// ----- src/wraparound_circle_collision_table.sv -----
`default_nettype none
// Channel   Handshake                          Payload
// -------   --------------------------------   --------------------------------------------
// command   start, busy (take: start & !busy)   i_cmd, i_spawn_x/y, i_step_x/y
// result    o_res_valid strobe, one cycle       o_object_index, o_out_x/y, o_hit,
//                                               o_valid_res, o_dropped, o_last
// config    APB psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// Spawn and tick on an empty table each run only the SPAWN or EMPTY control step; its
// result is registered in the result register.
// A tick's busy time is set by the single read port of the position memory, which the
// move, pair and report loops of the control program visit one entry per cycle; the pair
// loop covers each pair once and the report loop at most 16 objects.
// A tick with one object skips the pair loop. Reset is synchronous; the hit marks clear
// at once, positions and steps need no clearing. Results cannot be stalled.

module wraparound_circle_collision_table #(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cmd,
    input  logic [wcct_pkg::POS_W-1:0]            i_spawn_x,
    input  logic [wcct_pkg::POS_W-1:0]            i_spawn_y,
    input  logic signed [wcct_pkg::STEP_W-1:0]    i_step_x,
    input  logic signed [wcct_pkg::STEP_W-1:0]    i_step_y,
    output logic                                  o_res_valid,
    output logic [wcct_pkg::IDX_OUT_W-1:0]        o_object_index,
    output logic [wcct_pkg::POS_W-1:0]            o_out_x,
    output logic [wcct_pkg::POS_W-1:0]            o_out_y,
    output logic                                  o_hit,
    output logic                                  o_valid_res,
    output logic                                  o_dropped,
    output logic                                  o_last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wcct_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [wcct_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [wcct_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    import wcct_pkg::*;

    localparam int IDX_W = $clog2(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam int RES_W = $clog2(RES_LIMIT + 1);
    localparam int CMP_W = ((CNT_W > RES_W) ? CNT_W : RES_W) + 1;
    localparam int DIAM_W = RAD_W + 1;

    // Configuration registers
    logic [CFG_DIM_W-1:0] r_field_w;
    logic [CFG_DIM_W-1:0] r_field_h;
    logic [RAD_W-1:0]     r_radius;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_w <= FIELD_RESET;
            r_field_h <= FIELD_RESET;
            r_radius  <= RADIUS_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FIELD_WIDTH:   r_field_w <= pwdata[CFG_DIM_W-1:0];
                REG_FIELD_HEIGHT:  r_field_h <= pwdata[CFG_DIM_W-1:0];
                REG_OBJECT_RADIUS: r_radius  <= pwdata[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FIELD_WIDTH:   prdata = APB_DATA_W'(r_field_w);
            REG_FIELD_HEIGHT:  prdata = APB_DATA_W'(r_field_h);
            REG_OBJECT_RADIUS: prdata = APB_DATA_W'(r_radius);
            default:           prdata = '0;
        endcase
    end

    // Sequencer
    t_uword uw;
    t_flags flags;
    logic   accept;

    wcct_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uw    (uw),
        .o_busy  (busy)
    );

    assign accept = start && !busy;

    // Loop counters and per-transaction snapshot
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_count;
    logic [SQ_W-1:0]   r_lim;
    logic [POS_W-1:0]  r_sp_x;
    logic [POS_W-1:0]  r_sp_y;
    logic [STEP_W-1:0] r_st_x;
    logic [STEP_W-1:0] r_st_y;
    logic [DIAM_W-1:0] diam;
    logic [2*DIAM_W-1:0] diam_sq;

    logic [CMP_W-1:0] i_ext;
    logic [CMP_W-1:0] j_ext;
    logic [CMP_W-1:0] n_ext;
    logic [CMP_W-1:0] nr_ext;

    assign i_ext  = CMP_W'(r_i);
    assign j_ext  = CMP_W'(r_j);
    assign n_ext  = CMP_W'(r_n);
    assign nr_ext = (n_ext > CMP_W'(RES_LIMIT)) ? CMP_W'(RES_LIMIT) : n_ext;

    assign diam    = {r_radius, 1'b0};
    assign diam_sq = diam * diam;

    always_comb begin
        flags.accept      = accept;
        flags.entry       = i_cmd ? UPC_SPAWN :
                            ((r_count == '0) ? UPC_EMPTY : UPC_MOVE);
        flags.move_more   = (i_ext + CMP_W'(1)) < n_ext;
        flags.pair_more   = (j_ext + CMP_W'(1)) < n_ext;
        flags.outer_more  = (i_ext + CMP_W'(2)) < n_ext;
        flags.few         = n_ext < CMP_W'(2);
        flags.report_more = (i_ext + CMP_W'(1)) < nr_ext;
    end

    // Hold the command fields and the collision bound for the whole transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n    <= r_count;
            r_lim  <= {diam_sq, {(2 * FRAC_W){1'b0}}};
            r_sp_x <= i_spawn_x;
            r_sp_y <= i_spawn_y;
            r_st_x <= i_step_x;
            r_st_y <= i_step_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            case (uw.i_op)
                CNT_CLR: r_i <= '0;
                CNT_INC: r_i <= r_i + 1'b1;
                default: r_i <= r_i;
            endcase
            case (uw.j_op)
                CNT_CLR:  r_j <= '0;
                CNT_INC:  r_j <= r_j + 1'b1;
                CNT_LOAD: r_j <= r_i + 1'b1;
                default:  r_j <= r_j;
            endcase
        end
    end

    // Object memories: position pair and step pair share one read address
    logic [2*POS_W-1:0]  pos_rdata;
    logic [2*STEP_W-1:0] step_rdata;
    logic [2*POS_W-1:0]  pos_wdata;
    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic [IDX_W-1:0]    slot;
    logic                pos_we;
    logic                full;
    logic                spawn_ok;

    logic             wr_valid;
    logic [IDX_W-1:0] wr_addr;
    logic [POS_W-1:0] wr_x;
    logic [POS_W-1:0] wr_y;

    assign full     = r_count >= CNT_W'(MAX_OBJECTS);
    assign slot     = r_count[IDX_W-1:0];
    assign spawn_ok = (uw.emit == EMIT_SPAWN) && !full;
    assign raddr    = (uw.addr == ADDR_J) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
    assign pos_we   = spawn_ok || wr_valid;
    assign waddr    = spawn_ok ? slot : wr_addr;
    assign pos_wdata = spawn_ok ? {r_sp_x, r_sp_y} : {wr_x, wr_y};

    wcct_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (MAX_OBJECTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (waddr),
        .i_wdata (pos_wdata),
        .i_raddr (raddr),
        .o_rdata (pos_rdata)
    );

    wcct_ram #(
        .WIDTH (2 * STEP_W),
        .DEPTH (MAX_OBJECTS)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (spawn_ok),
        .i_waddr (slot),
        .i_wdata ({r_st_x, r_st_y}),
        .i_raddr (raddr),
        .o_rdata (step_rdata)
    );

    // Read tag: which loop the data returning next cycle belongs to
    logic             r_mv_v1;
    logic             r_pr_v1;
    logic             r_rp_v1;
    logic [IDX_W-1:0] r_tag1;
    logic             r_last1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_v1 <= 1'b0;
            r_pr_v1 <= 1'b0;
            r_rp_v1 <= 1'b0;
        end else begin
            r_mv_v1 <= (uw.sink == SINK_MOVE);
            r_pr_v1 <= (uw.sink == SINK_PAIR);
            r_rp_v1 <= (uw.sink == SINK_REPORT);
        end
        r_tag1  <= raddr;
        r_last1 <= (i_ext + CMP_W'(1)) == nr_ext;
    end

    // Move: add step in the wrap register, fold into the field, write back to the position memory
    wcct_wrap #(
        .ADDR_W (IDX_W)
    ) u_wrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_mv_v1),
        .i_addr   (r_tag1),
        .i_pos_x  (pos_rdata[2*POS_W-1:POS_W]),
        .i_pos_y  (pos_rdata[POS_W-1:0]),
        .i_step_x ($signed(step_rdata[2*STEP_W-1:STEP_W])),
        .i_step_y ($signed(step_rdata[STEP_W-1:0])),
        .i_size_x (r_field_w),
        .i_size_y (r_field_h),
        .o_valid  (wr_valid),
        .o_addr   (wr_addr),
        .o_x      (wr_x),
        .o_y      (wr_y)
    );

    // Pair check: hold object i, stream objects j past it
    logic [POS_W-1:0] r_xi;
    logic [POS_W-1:0] r_yi;
    logic [IDX_W-1:0] r_ia;
    logic             pair_hit;
    logic [IDX_W-1:0] pair_j;

    always_ff @(posedge i_clk) begin
        if (uw.latch) begin
            r_xi <= pos_rdata[2*POS_W-1:POS_W];
            r_yi <= pos_rdata[POS_W-1:0];
            r_ia <= r_i[IDX_W-1:0];
        end
    end

    wcct_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pr_v1),
        .i_j     (r_tag1),
        .i_xi    (r_xi),
        .i_yi    (r_yi),
        .i_xj    (pos_rdata[2*POS_W-1:POS_W]),
        .i_yj    (pos_rdata[POS_W-1:0]),
        .i_lim   (r_lim),
        .o_hit   (pair_hit),
        .o_j     (pair_j)
    );

    // Table fill count and sticky hit marks
    logic [MAX_OBJECTS-1:0] r_hit;
    logic [MAX_OBJECTS-1:0] n_hit;

    // Clear the mark of a fresh slot, set both marks of an overlapping pair
    always_comb begin
        n_hit = r_hit;
        if (spawn_ok) begin
            n_hit[slot] = 1'b0;
        end
        if (pair_hit) begin
            n_hit[r_ia]   = 1'b1;
            n_hit[pair_j] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= '0;
        end else begin
            if (spawn_ok) begin
                r_count <= r_count + 1'b1;
            end
            r_hit <= n_hit;
        end
    end

    // Result register: strobe for one cycle per transaction result
    logic                 r_res_valid;
    logic [IDX_OUT_W-1:0] r_index;
    logic [POS_W-1:0]     r_out_x;
    logic [POS_W-1:0]     r_out_y;
    logic                 r_hit_out;
    logic                 r_valid_res;
    logic                 r_dropped;
    logic                 r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (uw.emit == EMIT_SPAWN) || (uw.emit == EMIT_EMPTY) || r_rp_v1;
        end
        if (uw.emit == EMIT_SPAWN) begin
            r_index     <= full ? '0 : IDX_OUT_W'(slot);
            r_out_x     <= full ? '0 : r_sp_x;
            r_out_y     <= full ? '0 : r_sp_y;
            r_hit_out   <= 1'b0;
            r_valid_res <= !full;
            r_dropped   <= full;
            r_last      <= 1'b1;
        end else if (uw.emit == EMIT_EMPTY) begin
            r_index     <= '0;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_hit_out   <= 1'b0;
            r_valid_res <= 1'b0;
            r_dropped   <= 1'b0;
            r_last      <= 1'b1;
        end else begin
            r_index     <= IDX_OUT_W'(r_tag1);
            r_out_x     <= pos_rdata[2*POS_W-1:POS_W];
            r_out_y     <= pos_rdata[POS_W-1:0];
            r_hit_out   <= r_hit[r_tag1];
            r_valid_res <= 1'b1;
            r_dropped   <= 1'b0;
            r_last      <= r_last1;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_object_index = r_index;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_hit          = r_hit_out;
    assign o_valid_res    = r_valid_res;
    assign o_dropped      = r_dropped;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ----- src/wcct_check.sv -----
`default_nettype none

module wcct_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cmd,
    input logic o_res_valid,
    input logic o_hit,
    input logic o_valid_res,
    input logic o_dropped,
    input logic o_last
);

    // The block is busy in the cycle after it takes a transaction
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking a transaction");

    // A spawn answers with its single, final result through the sequencer and result registers
    a_spawn_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd) |-> ##2 (o_res_valid && o_last))
        else $error("spawn result missing or not final");

    // A refused spawn describes no object
    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_dropped) |-> (!o_valid_res && !o_hit && o_last))
        else $error("dropped result carries object state");

    // Nothing follows directly after the final result of a transaction
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_last) |=> !o_res_valid)
        else $error("result strobe right after final result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_res_valid))
        else $error("block not idle after reset");

endmodule

bind wraparound_circle_collision_table wcct_check u_wcct_check (.*);

`default_nettype wire
